FILE: hdl/hbs_pkg.sv
package hbs_pkg;

  // Grid and fixed-point geometry
  localparam int MAX_GRID_DIM = 128;
  localparam int FRAC_BITS    = 8;

  localparam int IDX_W    = $clog2(MAX_GRID_DIM);
  localparam int COORD_W  = 17;
  localparam int DIM_W    = 8;
  localparam int HEIGHT_W = 16;
  localparam int FRAC_W   = FRAC_BITS + 1;
  localparam int CLAMP_W  = IDX_W + FRAC_BITS;

  // Four banks split by column and row parity, each a quarter of the grid
  localparam int NUM_BANKS  = 4;
  localparam int BANK_DEPTH = (MAX_GRID_DIM / 2) * (MAX_GRID_DIM / 2);
  localparam int BANK_AW    = 2 * (IDX_W - 1);

  // Arithmetic widths of the blend
  localparam int PROD_W  = HEIGHT_W + FRAC_W + 1;
  localparam int BLEND_W = PROD_W + FRAC_W + 1;

  // Items in flight from input register to output register
  localparam int PIPE_DEPTH = 6;
  localparam int PEND_W     = $clog2(PIPE_DEPTH + 1);

  // Operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_LENGTH = CFG_IDX_W'(1);

  typedef struct packed {
    logic [IDX_W-1:0]  tile;
    logic [FRAC_W-1:0] frac;
  } coord_split_t;

  // Clamp a coordinate to the grid in use and split it into cell and fraction.
  function automatic coord_split_t split_coord(input logic signed [COORD_W-1:0] pos,
                                               input logic [DIM_W-1:0] dim_reg);
    logic [DIM_W-1:0]   n;
    logic [CLAMP_W-1:0] top;
    logic [CLAMP_W-1:0] c;
    logic [IDX_W-1:0]   tile;
    coord_split_t       r;
    if (dim_reg < DIM_W'(2)) begin
      n = DIM_W'(2);
    end else if (dim_reg > DIM_W'(MAX_GRID_DIM)) begin
      n = DIM_W'(MAX_GRID_DIM);
    end else begin
      n = dim_reg;
    end
    top = CLAMP_W'(n - DIM_W'(1)) << FRAC_BITS;
    if (pos[COORD_W-1]) begin
      c = '0;
    end else if (pos[COORD_W-2:0] > (COORD_W-1)'(top)) begin
      c = top;
    end else begin
      c = CLAMP_W'(pos[COORD_W-2:0]);
    end
    tile = c[CLAMP_W-1:FRAC_BITS];
    // Last cell: step back one and take a full fraction
    if (DIM_W'(tile) >= n - DIM_W'(1)) begin
      r.tile = IDX_W'(n - DIM_W'(2));
      r.frac = FRAC_W'(1) << FRAC_BITS;
    end else begin
      r.tile = tile;
      r.frac = {1'b0, c[FRAC_BITS-1:0]};
    end
    return r;
  endfunction

endpackage

FILE: hdl/heightmap_bilinear_sampler.sv
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    operation, pos_x, pos_z, write_col/row/height
// out       output     out_valid_o / out_ready_i  sampled_height
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One transaction per cycle on the input while it is not stalled; a sample result is presented
// from the output register, a write gives no result. The pipeline runs input register, bank
// read, x products, x sums, z products, round into the output register.
// Each stage advances whenever the next one is empty or moving, so bubbles collapse;
// the input stalls only once all six stages hold a transaction and the result waits.
// Reset clears the valid bits and sets both grid sizes to 128; heights are not cleared.
module heightmap_bilinear_sampler (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  operation_i,
  input  logic signed [hbs_pkg::COORD_W-1:0]    pos_x_i,
  input  logic signed [hbs_pkg::COORD_W-1:0]    pos_z_i,
  input  logic        [hbs_pkg::IDX_W-1:0]      write_col_i,
  input  logic        [hbs_pkg::IDX_W-1:0]      write_row_i,
  input  logic signed [hbs_pkg::HEIGHT_W-1:0]   write_height_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [hbs_pkg::HEIGHT_W-1:0]   sampled_height_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic        [hbs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [hbs_pkg::DIM_W-1:0]      cfg_data_i
);
  import hbs_pkg::*;

  // Configuration registers
  logic [DIM_W-1:0] grid_width_q, grid_length_q;

  // Stage A: input register
  logic                       a_valid_q, a_op_q;
  logic signed [COORD_W-1:0]  a_pos_x_q, a_pos_z_q;
  logic [IDX_W-1:0]           a_col_q, a_row_q;
  logic signed [HEIGHT_W-1:0] a_height_q;

  // Stage B: bank read data and fractions
  logic                       b_valid_q;
  logic [FRAC_W-1:0]          b_fx_q, b_fz_q;
  logic                       b_px_q, b_pz_q;
  logic signed [HEIGHT_W-1:0] rd_q [NUM_BANKS];

  // Stage C: corner products along x
  logic                       c_valid_q;
  logic [FRAC_W-1:0]          c_fz_q;
  logic signed [PROD_W-1:0]   c_p00_q, c_p10_q, c_p01_q, c_p11_q;

  // Stage D: blends along x
  logic                       d_valid_q;
  logic [FRAC_W-1:0]          d_fz_q;
  logic signed [PROD_W-1:0]   d_a0_q, d_a1_q;

  // Stage E: weighted along z
  logic                       e_valid_q;
  logic signed [BLEND_W-1:0]  e_q0_q, e_q1_q;

  // Stage F: output register
  logic                       out_valid_q;
  logic signed [HEIGHT_W-1:0] out_height_q;

  logic a_en, b_en, c_en, d_en, e_en, f_en;

  // Height banks, split by {row parity, column parity}
  logic [HEIGHT_W-1:0] mem [NUM_BANKS][BANK_DEPTH];

  coord_split_t      sx, sz;
  logic [BANK_AW-1:0] rd_addr [NUM_BANKS];
  logic [BANK_AW-1:0] wr_addr;
  logic [1:0]         wr_bank;
  logic               wr_en;

  logic [FRAC_W-1:0]          wx0, wz0;
  logic signed [HEIGHT_W-1:0] h00, h10, h01, h11;
  logic signed [BLEND_W-1:0]  blend_sum;

  // Advance a stage when it is empty or its successor takes its content
  assign f_en = !out_valid_q || out_ready_i;
  assign e_en = !e_valid_q || f_en;
  assign d_en = !d_valid_q || e_en;
  assign c_en = !c_valid_q || d_en;
  assign b_en = !b_valid_q || c_en;
  assign a_en = !a_valid_q || b_en;

  assign in_ready_o       = a_en;
  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign sampled_height_o = out_height_q;

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= DIM_W'(MAX_GRID_DIM);
      grid_length_q <= DIM_W'(MAX_GRID_DIM);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i;
        CFG_GRID_LENGTH: grid_length_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage A capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_en) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en && in_valid_i) begin
      a_op_q     <= operation_i;
      a_pos_x_q  <= pos_x_i;
      a_pos_z_q  <= pos_z_i;
      a_col_q    <= write_col_i;
      a_row_q    <= write_row_i;
      a_height_q <= write_height_i;
    end
  end

  // Clamp, split and form one address per bank. The four corners always fall
  // in four different banks, so each bank serves one of them.
  always_comb begin
    logic [IDX_W-1:0] col, row;
    sx = split_coord(a_pos_x_q, grid_width_q);
    sz = split_coord(a_pos_z_q, grid_length_q);
    for (int b = 0; b < NUM_BANKS; b++) begin
      col = sx.tile + IDX_W'(b[0] ^ sx.tile[0]);
      row = sz.tile + IDX_W'(b[1] ^ sz.tile[0]);
      rd_addr[b] = {row[IDX_W-1:1], col[IDX_W-1:1]};
    end
  end

  // Writes leave stage A in order with samples, so a later sample sees them
  assign wr_en   = a_valid_q && (a_op_q == OP_WRITE) && b_en;
  assign wr_bank = {a_row_q[0], a_col_q[0]};
  assign wr_addr = {a_row_q[IDX_W-1:1], a_col_q[IDX_W-1:1]};

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      if (wr_en && (wr_bank == 2'(b))) begin
        mem[b][wr_addr] <= a_height_q;
      end
      if (b_en) begin
        rd_q[b] <= mem[b][rd_addr[b]];
      end
    end
  end

  // Stage B valid: only samples go on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_en) begin
      b_valid_q <= a_valid_q && (a_op_q == OP_SAMPLE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_en) begin
      b_fx_q <= sx.frac;
      b_fz_q <= sz.frac;
      b_px_q <= sx.tile[0];
      b_pz_q <= sz.tile[0];
    end
  end

  // Route bank data back to corners
  assign h00 = rd_q[{b_pz_q, b_px_q}];
  assign h10 = rd_q[{b_pz_q, !b_px_q}];
  assign h01 = rd_q[{!b_pz_q, b_px_q}];
  assign h11 = rd_q[{!b_pz_q, !b_px_q}];
  assign wx0 = (FRAC_W'(1) << FRAC_BITS) - b_fx_q;

  // Stage C
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_en) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_en) begin
      c_fz_q  <= b_fz_q;
      c_p00_q <= $signed({1'b0, wx0}) * h00;
      c_p10_q <= $signed({1'b0, b_fx_q}) * h10;
      c_p01_q <= $signed({1'b0, wx0}) * h01;
      c_p11_q <= $signed({1'b0, b_fx_q}) * h11;
    end
  end

  // Stage D: convex blend along x stays within PROD_W
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (d_en) begin
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_en) begin
      d_fz_q <= c_fz_q;
      d_a0_q <= c_p00_q + c_p10_q;
      d_a1_q <= c_p01_q + c_p11_q;
    end
  end

  assign wz0 = (FRAC_W'(1) << FRAC_BITS) - d_fz_q;

  // Stage E
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (e_en) begin
      e_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_en) begin
      e_q0_q <= d_a0_q * $signed({1'b0, wz0});
      e_q1_q <= d_a1_q * $signed({1'b0, d_fz_q});
    end
  end

  // Round half up: add one half, take the floor by dropping the fraction bits
  assign blend_sum = e_q0_q + e_q1_q + (BLEND_W'(1) <<< (2 * FRAC_BITS - 1));

  // Stage F: hold the result until the consumer takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (f_en) begin
      out_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_en && e_valid_q) begin
      out_height_q <= blend_sum[2*FRAC_BITS +: HEIGHT_W];
    end
  end

endmodule

FILE: hdl/hbs_checker.sv
module hbs_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_ready_o,
  input logic                                  operation_i,
  input logic                                  out_valid_o,
  input logic                                  out_ready_i,
  input logic signed [hbs_pkg::HEIGHT_W-1:0]   sampled_height_o,
  input logic                                  cfg_ready_o
);
  import hbs_pkg::*;

  logic [PEND_W-1:0] pending_q;
  logic              inc, dec;

  // Track samples accepted but not yet delivered
  assign inc = in_valid_i && in_ready_o && (operation_i == OP_SAMPLE);
  assign dec = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + PEND_W'(inc) - PEND_W'(dec);
    end
  end

  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pending_q != '0))
    else $error("result without an outstanding sample");

  a_pending_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= PEND_W'(PIPE_DEPTH))
    else $error("more samples in flight than pipeline stages");

  a_cfg_always_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(sampled_height_o)))
    else $error("stalled result dropped or changed");

endmodule

bind heightmap_bilinear_sampler hbs_checker u_hbs_checker (.*);

FILE: tb/heightmap_bilinear_sampler_test.sv
`timescale 1ns / 100ps

module heightmap_bilinear_sampler_test;
  import hbs_pkg::*;

  // Run bounds: generous cycle budget, long output hold, pipeline settle time
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES   = 240;
  localparam int SETTLE_CYCLES = PIPE_DEPTH + 4;
  localparam int STORE_DEPTH   = MAX_GRID_DIM * MAX_GRID_DIM;

  // Register indexes the block does not implement; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [HEIGHT_W-1:0] height_t;
  typedef struct {
    int tile;
    int frac;
  } axis_t;

  localparam height_t HEIGHT_MAX = {1'b0, {(HEIGHT_W-1){1'b1}}};
  localparam height_t HEIGHT_MIN = {1'b1, {(HEIGHT_W-1){1'b0}}};

  // Block ports; every input starts at a known value
  logic                  clk_i;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic                  operation_i    = OP_WRITE;
  coord_t                pos_x_i        = '0;
  coord_t                pos_z_i        = '0;
  logic [IDX_W-1:0]      write_col_i    = '0;
  logic [IDX_W-1:0]      write_row_i    = '0;
  height_t               write_height_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  height_t               sampled_height_o;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = CFG_GRID_WIDTH;
  logic [DIM_W-1:0]      cfg_data_i     = '0;

  // Shadow of the height grid and of the size registers
  height_t          grid_heights [STORE_DEPTH];
  bit               grid_written [STORE_DEPTH];
  logic [DIM_W-1:0] width_shadow  = DIM_W'(MAX_GRID_DIM);
  logic [DIM_W-1:0] length_shadow = DIM_W'(MAX_GRID_DIM);

  // Heights the block still owes us, oldest first
  height_t     expected_heights [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Idle bursts on both sides; cleared for the closing stretch
  bit          idle_en  = 1'b1;
  // Bump to make the receiver hold off for HOLD_CYCLES
  int unsigned hold_seq = 0;

  heightmap_bilinear_sampler u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .pos_x_i          (pos_x_i),
    .pos_z_i          (pos_z_i),
    .write_col_i      (write_col_i),
    .write_row_i      (write_row_i),
    .write_height_i   (write_height_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sampled_height_o (sampled_height_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Size register to grid size actually used: below 2 acts as 2, above max as max
  function automatic int dim_in_use(logic [DIM_W-1:0] reg_val);
    if (reg_val < DIM_W'(2)) return 2;
    if (reg_val > DIM_W'(MAX_GRID_DIM)) return MAX_GRID_DIM;
    return int'(reg_val);
  endfunction

  // Clamp one coordinate into [0, (n-1)*S], then split into cell and fraction.
  // On the last column or row, step the cell back and use a full fraction.
  function automatic axis_t locate_axis(coord_t pos, logic [DIM_W-1:0] reg_val);
    int    n;
    int    top;
    int    c;
    axis_t a;
    n   = dim_in_use(reg_val);
    top = (n - 1) << FRAC_BITS;
    c   = pos;
    if (c < 0) begin
      c = 0;
    end else if (c > top) begin
      c = top;
    end
    a.tile = c >>> FRAC_BITS;
    if (a.tile >= n - 1) a.tile = n - 2;
    a.frac = c - (a.tile << FRAC_BITS);
    return a;
  endfunction

  function automatic longint grid_height_at(int col, int row);
    return longint'(grid_heights[row * MAX_GRID_DIM + col]);
  endfunction

  // Exact bilinear blend over S*S, rounded to nearest with halves going up
  function automatic height_t predict_height(coord_t x, coord_t z);
    axis_t  ax;
    axis_t  az;
    longint one;
    longint sum;
    ax  = locate_axis(x, width_shadow);
    az  = locate_axis(z, length_shadow);
    one = longint'(1) << FRAC_BITS;
    sum = (one - ax.frac) * (one - az.frac) * grid_height_at(ax.tile, az.tile)
        + (one - ax.frac) * az.frac * grid_height_at(ax.tile, az.tile + 1)
        + ax.frac * (one - az.frac) * grid_height_at(ax.tile + 1, az.tile)
        + ax.frac * az.frac * grid_height_at(ax.tile + 1, az.tile + 1);
    sum = sum + (longint'(1) << (2 * FRAC_BITS - 1));
    return height_t'(sum >>> (2 * FRAC_BITS));
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("%0t ns: sampled height mismatch: %s", $time, what);
  endtask

  // Compare every accepted result with the oldest outstanding prediction
  always @(posedge clk_i) begin : check_results
    height_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_heights.size() == 0) begin
        report_mismatch($sformatf("got %0d with no sample pending", sampled_height_o));
      end else begin
        want = expected_heights.pop_front();
        if (sampled_height_o !== want)
          report_mismatch($sformatf("got %0d, expected %0d", sampled_height_o, want));
      end
    end
  end

  // Hard stop if the run hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, calm stretches, and the long hold on request
  // ---------------------------------------------------------------------------

  initial begin : sink_ctrl
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned hold_seen;
    stall_left = 0;
    calm_left  = 0;
    hold_seen  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != hold_seen) begin
        // Hold off long enough for the pipeline to fill and back up the input
        hold_seen  = hold_seq;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && calm_left == 0 && idle_en) begin
        case ($urandom_range(0, 9))
          0, 1: stall_left = $urandom_range(1, 8);
          2:    calm_left  = $urandom_range(20, 60);
          default: ;
        endcase
      end
      if (calm_left != 0) calm_left--;
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one input transaction and hold it until accepted. Valid stays high on
  // return so back-to-back transactions need no second assignment in one step.
  task automatic push_item(logic op, coord_t x, coord_t z, logic [IDX_W-1:0] col,
                           logic [IDX_W-1:0] row, height_t h);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    pos_x_i        <= x;
    pos_z_i        <= z;
    write_col_i    <= col;
    write_row_i    <= row;
    write_height_i <= h;
    do @(posedge clk_i); while (!in_ready_o);
    // Accepted at this edge: advance the shadow or queue the prediction
    if (op == OP_WRITE) begin
      grid_heights[row * MAX_GRID_DIM + col] = h;
      grid_written[row * MAX_GRID_DIM + col] = 1'b1;
    end else begin
      expected_heights = {expected_heights, predict_height(x, z)};
    end
  endtask

  // Position fields are don't-care on a write; drive noise there
  task automatic write_height(int col, int row, height_t h);
    push_item(OP_WRITE, coord_t'($urandom), coord_t'($urandom), IDX_W'(col), IDX_W'(row), h);
  endtask

  function automatic height_t any_height();
    case ($urandom_range(0, 7))
      0:       return HEIGHT_MAX;
      1:       return HEIGHT_MIN;
      2:       return height_t'(int'($urandom_range(0, 8)) - 4);
      default: return height_t'($urandom);
    endcase
  endfunction

  // Never read an entry that was not written: store any missing corner first
  task automatic sample_at(coord_t x, coord_t z);
    axis_t ax;
    axis_t az;
    int    col;
    int    row;
    ax = locate_axis(x, width_shadow);
    az = locate_axis(z, length_shadow);
    for (int dz = 0; dz < 2; dz++) begin
      for (int dx = 0; dx < 2; dx++) begin
        col = ax.tile + dx;
        row = az.tile + dz;
        if (!grid_written[row * MAX_GRID_DIM + col]) write_height(col, row, any_height());
      end
    end
    push_item(OP_SAMPLE, x, z, IDX_W'($urandom), IDX_W'($urandom), height_t'($urandom));
  endtask

  // Mix of in-grid, on-grid-line, last-cell, below-zero, past-edge and raw positions
  function automatic coord_t any_pos(logic [DIM_W-1:0] reg_val);
    int top;
    top = (dim_in_use(reg_val) - 1) << FRAC_BITS;
    case ($urandom_range(0, 9))
      0:       return coord_t'(-int'($urandom_range(1, 65536)));
      1:       return coord_t'($urandom_range(top, 65535));
      2:       return coord_t'(top);
      3:       return coord_t'($urandom);
      4:       return coord_t'($urandom_range(0, top >> FRAC_BITS) << FRAC_BITS);
      default: return coord_t'($urandom_range(0, top));
    endcase
  endfunction

  // Drop valid and wait until every predicted sample has come back
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_heights.size() != 0);
  endtask

  // One config transaction; valid stays high so the caller can chain writes
  task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_GRID_WIDTH) begin
      width_shadow = data;
    end else if (idx == CFG_GRID_LENGTH) begin
      length_shadow = data;
    end
  endtask

  // Resize only while idle: drain results, let trailing writes retire, then write
  task automatic set_grid_size(logic [DIM_W-1:0] w, logic [DIM_W-1:0] l);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_put(CFG_GRID_WIDTH, w);
    cfg_put(CFG_SPARE_2, DIM_W'($urandom));
    cfg_put(CFG_GRID_LENGTH, l);
    cfg_put(CFG_SPARE_3, DIM_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly samples; writes land anywhere or inside the grid in use
  task automatic random_traffic(int count);
    repeat (count) begin
      case ($urandom_range(0, 9))
        0:    write_height($urandom_range(0, MAX_GRID_DIM - 1),
                           $urandom_range(0, MAX_GRID_DIM - 1), any_height());
        1, 2: write_height($urandom_range(0, dim_in_use(width_shadow) - 1),
                           $urandom_range(0, dim_in_use(length_shadow) - 1), any_height());
        default: sample_at(any_pos(width_shadow), any_pos(length_shadow));
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset (128 x 128): far corner, last-cell step back, negative halves
  task automatic test_far_corner();
    int last;
    last = MAX_GRID_DIM - 1;
    write_height(last,     last,     HEIGHT_MAX);
    write_height(last - 1, last,     HEIGHT_MIN);
    write_height(last,     last - 1, HEIGHT_MIN);
    write_height(last - 1, last - 1, HEIGHT_MAX);
    // Past the far edge on both axes: clamps to the last corner exactly
    sample_at(coord_t'(65535), coord_t'(65535));
    // On the last column, halfway along z: blend is -0.5, rounds up to 0
    sample_at(coord_t'(last << FRAC_BITS), coord_t'(((last - 1) << FRAC_BITS) + 128));
    // Center of the last cell: also -0.5
    sample_at(coord_t'(((last - 1) << FRAC_BITS) + 128),
              coord_t'(((last - 1) << FRAC_BITS) + 128));
    // Most negative position clamps to the origin
    sample_at(coord_t'(-65536), coord_t'(-65536));
    sample_at(coord_t'(-1), coord_t'(0));
  endtask

  // Size registers below 2 and above max, unknown indexes, positive half
  task automatic test_size_limits();
    set_grid_size(DIM_W'(0), DIM_W'(1));
    write_height(0, 0, height_t'(0));
    write_height(1, 0, height_t'(1));
    write_height(0, 1, height_t'(-1));
    write_height(1, 1, HEIGHT_MIN);
    sample_at(coord_t'(128), coord_t'(0));        // +0.5 rounds to 1
    sample_at(coord_t'(0), coord_t'(128));        // -0.5 rounds to 0
    sample_at(coord_t'(65535), coord_t'(65535));  // last cell on both axes
    sample_at(coord_t'(200), coord_t'(77));
    set_grid_size(DIM_W'(255), DIM_W'(MAX_GRID_DIM + 1));
    sample_at(coord_t'(65535), coord_t'(0));
    sample_at(coord_t'(0), coord_t'(65535));
  endtask

  // Several grid shapes, extremes first, then random register values, then the full grid
  task automatic test_random_grids();
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] l;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin w = DIM_W'(2);            l = DIM_W'(2);            end
        1: begin w = DIM_W'(3);            l = DIM_W'(7);            end
        2: begin w = DIM_W'(MAX_GRID_DIM); l = DIM_W'(2);            end
        3: begin w = DIM_W'(2);            l = DIM_W'(MAX_GRID_DIM); end
        7: begin w = DIM_W'(MAX_GRID_DIM); l = DIM_W'(MAX_GRID_DIM); end
        default: begin
          w = DIM_W'($urandom_range(0, 255));
          l = DIM_W'($urandom_range(0, 255));
        end
      endcase
      set_grid_size(w, l);
      random_traffic(55);
    end
  endtask

  // Receiver holds off while the sender keeps offering; then pause for a full drain
  task automatic test_output_hold();
    idle_en  = 1'b0;
    hold_seq <= hold_seq + 1;
    random_traffic(30);
    wait_results_drained();
    idle_en  = 1'b1;
  endtask

  // Closing stretch at full rate with no idling on either side
  task automatic test_streaming();
    idle_en = 1'b0;
    random_traffic(60);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_far_corner();
    test_size_limits();
    test_random_grids();
    test_output_hold();
    test_streaming();
    // Wait out the last results, then give stray outputs a chance to show up
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/hbs_pkg.sv
hdl/heightmap_bilinear_sampler.sv
hdl/hbs_checker.sv
tb/heightmap_bilinear_sampler_test.sv
